[rtl/asd_pkg.sv]
package asd_pkg;

    localparam int unsigned ADC_MAX_DEF  = 4095;
    localparam int unsigned RAW_W        = 12;
    localparam int unsigned RAW_STATE_W  = 14;
    localparam int unsigned OFFSET_W     = 13;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned PCT_W        = 7;
    localparam int unsigned PCT_FULL     = 100;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned CFG_IDX_W    = 2;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_INIT   = 1'b1;

    localparam logic [OFFSET_W-1:0] ZERO_OFFSET_RST   = '0;
    localparam logic [RAW_W-1:0]    RAW_THRESHOLD_RST = RAW_W'(10);
    localparam logic [TIME_W-1:0]   INTERVAL_MS_RST   = TIME_W'(50);
    localparam logic                INVERT_RST        = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_OFFSET,
        CFG_RAW_THRESHOLD,
        CFG_INTERVAL_MS,
        CFG_INVERT
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REASON_NONE,
        REASON_MOVED,
        REASON_INIT
    } t_reason;

    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] now_ms;
        logic [RAW_W-1:0]  sample;
    } t_in;

    typedef struct packed {
        logic             changed;
        logic [PCT_W-1:0] percent;
        logic [RAW_W-1:0] raw_now;
        logic [RAW_W-1:0] raw_before;
        logic [1:0]       reason;
    } t_out;

    typedef struct packed {
        logic [OFFSET_W-1:0] zero_offset;
        logic [RAW_W-1:0]    raw_threshold;
        logic [TIME_W-1:0]   interval_ms;
        logic                invert;
    } t_cfg;

    // width of a clamped raw value
    function automatic int unsigned asd_cw(input int unsigned adc_max);
        return $clog2(adc_max + 1);
    endfunction

    // width of the signed stored raw value (unclamped init values fit too)
    function automatic int unsigned asd_sw(input int unsigned adc_max);
        int unsigned cw;
        cw = $clog2(adc_max + 1);
        return (cw + 1 > RAW_STATE_W) ? cw + 1 : RAW_STATE_W;
    endfunction

endpackage

[rtl/asd_cfg.sv]
module asd_cfg
    import asd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_offset   <= ZERO_OFFSET_RST;
            r_cfg.raw_threshold <= RAW_THRESHOLD_RST;
            r_cfg.interval_ms   <= INTERVAL_MS_RST;
            r_cfg.invert        <= INVERT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ZERO_OFFSET:   r_cfg.zero_offset   <= i_cfg_data[OFFSET_W-1:0];
                CFG_RAW_THRESHOLD: r_cfg.raw_threshold <= i_cfg_data[RAW_W-1:0];
                CFG_INTERVAL_MS:   r_cfg.interval_ms   <= i_cfg_data[TIME_W-1:0];
                CFG_INVERT:        r_cfg.invert        <= i_cfg_data[0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/asd_scale.sv]
module asd_scale
    import asd_pkg::*;
#(
    parameter int unsigned ADC_MAX = ADC_MAX_DEF
) (
    input  logic [asd_cw(ADC_MAX)-1:0] i_raw,
    output logic [PCT_W-1:0]           o_pct
);

    // floor(raw * 100 / ADC_MAX) as raw * ceil(100 * 2^K / ADC_MAX) >> K;
    // exact for raw <= ADC_MAX because 2^K > ADC_MAX^2
    localparam int unsigned CW = asd_cw(ADC_MAX);
    localparam int unsigned K  = 2 * CW;
    localparam longint unsigned RECIP =
        ((64'(PCT_FULL) << K) + 64'(ADC_MAX) - 64'd1) / 64'(ADC_MAX);
    localparam int unsigned RW = $clog2(RECIP + 1);
    localparam int unsigned PW = K + PCT_W + 1;

    logic [RW-1:0] w_recip;
    logic [PW-1:0] w_prod;

    assign w_recip = RW'(RECIP);
    assign w_prod  = PW'(i_raw) * PW'(w_recip);
    assign o_pct   = w_prod[K +: PCT_W];

endmodule

[rtl/asd_step.sv]
module asd_step
    import asd_pkg::*;
#(
    parameter int unsigned ADC_MAX = ADC_MAX_DEF
) (
    input  t_in                         i_in,
    input  t_cfg                        i_cfg,
    input  logic [TIME_W-1:0]           i_last,
    input  logic [asd_sw(ADC_MAX)-1:0]  i_stored,
    input  logic [asd_sw(ADC_MAX)-1:0]  i_prev,
    input  logic [PCT_W-1:0]            i_pct,
    output logic [TIME_W-1:0]           o_last,
    output logic [asd_sw(ADC_MAX)-1:0]  o_stored,
    output logic [asd_sw(ADC_MAX)-1:0]  o_prev,
    output logic [PCT_W-1:0]            o_pct,
    output t_out                        o_res
);

    localparam int unsigned CW = asd_cw(ADC_MAX);
    localparam int unsigned SW = asd_sw(ADC_MAX);
    localparam logic signed [SW-1:0] MAX_S = SW'(ADC_MAX);

    function automatic logic [SW-1:0] clamp_raw(input logic signed [SW-1:0] v);
        logic [SW-1:0] r;
        if (v[SW-1])
            r = '0;
        else if (v > MAX_S)
            r = MAX_S;
        else
            r = v;
        return r;
    endfunction

    logic signed [SW-1:0] w_off;
    logic [SW-1:0]        w_off_c;
    logic [CW-1:0]        w_clamp;
    logic [CW-1:0]        w_nr;
    logic [SW-1:0]        w_nr_s;
    logic signed [SW:0]   w_diff;
    logic [SW:0]          w_abs;
    logic                 w_moved;
    logic [TIME_W-1:0]    w_elapsed;
    logic                 w_due;
    logic [CW-1:0]        w_pct_in;
    logic [PCT_W-1:0]     w_pct;
    logic [SW-1:0]        w_now_c;
    logic [SW-1:0]        w_prev_c;
    logic                 w_changed;
    t_reason              w_reason;

    assign w_off = $signed({{(SW-RAW_W){1'b0}}, i_in.sample})
                 - $signed({{(SW-OFFSET_W){i_cfg.zero_offset[OFFSET_W-1]}},
                            i_cfg.zero_offset});
    assign w_off_c = clamp_raw(w_off);
    assign w_clamp = w_off_c[CW-1:0];
    assign w_nr    = i_cfg.invert ? CW'(ADC_MAX) - w_clamp : w_clamp;
    assign w_nr_s  = SW'(w_nr);

    assign w_diff  = $signed({w_nr_s[SW-1], w_nr_s}) - $signed({i_stored[SW-1], i_stored});
    assign w_abs   = w_diff[SW] ? -w_diff : w_diff;
    assign w_moved = w_abs >= (SW+1)'(i_cfg.raw_threshold);

    // unsigned difference handles timestamp wrap
    assign w_elapsed = i_in.now_ms - i_last;
    assign w_due     = w_elapsed >= i_cfg.interval_ms;

    // init and update never need the scaler in the same transaction
    assign w_pct_in = (i_in.mode == MODE_INIT) ? w_clamp : w_nr;

    asd_scale #(
        .ADC_MAX (ADC_MAX)
    ) u_scale (
        .i_raw (w_pct_in),
        .o_pct (w_pct)
    );

    always_comb begin
        o_last    = i_last;
        o_stored  = i_stored;
        o_prev    = i_prev;
        o_pct     = i_pct;
        w_changed = 1'b0;
        w_reason  = REASON_NONE;
        if (i_in.mode == MODE_INIT) begin
            o_stored = w_off;
            o_pct    = w_pct;
            w_reason = REASON_INIT;
        end else if (w_due) begin
            o_last = i_in.now_ms;
            if (w_moved) begin
                o_prev   = i_stored;
                o_stored = w_nr_s;
                if (w_pct != i_pct) begin
                    o_pct     = w_pct;
                    w_changed = 1'b1;
                    w_reason  = REASON_MOVED;
                end
            end
        end
    end

    assign w_now_c  = clamp_raw(o_stored);
    assign w_prev_c = clamp_raw(o_prev);

    assign o_res.changed    = w_changed;
    assign o_res.percent    = o_pct;
    assign o_res.raw_now    = w_now_c[RAW_W-1:0];
    assign o_res.raw_before = w_prev_c[RAW_W-1:0];
    assign o_res.reason     = w_reason;

endmodule

[rtl/analog_slider_deadband.sv]
// The input register captures each input transaction; the step logic then loads the
// result register from it. Throughput: one transaction per cycle while the output is
// not stalled; the input register, one pass through the offset/clamp/compare logic and
// the reciprocal multiplier, and the result register. Stalls on the output hold the
// result and block new input only once both registers fill.
// Reset: synchronous, active low; clears the valid flags, config to its reset values and
// slider state to zero. No clearing pass; input ready from the first reset edge on.
module analog_slider_deadband
    import asd_pkg::*;
#(
    parameter int unsigned ADC_MAX = ADC_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned SW = asd_sw(ADC_MAX);

    t_cfg              w_cfg;
    logic              r_in_valid;
    t_in               r_in;
    logic              r_out_valid;
    t_out              r_out;
    logic [TIME_W-1:0] r_last;
    logic [SW-1:0]     r_stored;
    logic [SW-1:0]     r_prev;
    logic [PCT_W-1:0]  r_pct;
    logic [TIME_W-1:0] n_last;
    logic [SW-1:0]     n_stored;
    logic [SW-1:0]     n_prev;
    logic [PCT_W-1:0]  n_pct;
    t_out              n_out;
    logic              w_adv;

    asd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    asd_step #(
        .ADC_MAX (ADC_MAX)
    ) u_step (
        .i_in     (r_in),
        .i_cfg    (w_cfg),
        .i_last   (r_last),
        .i_stored (r_stored),
        .i_prev   (r_prev),
        .i_pct    (r_pct),
        .o_last   (n_last),
        .o_stored (n_stored),
        .o_prev   (n_prev),
        .o_pct    (n_pct),
        .o_res    (n_out)
    );

    // state commits in the same edge that loads the result register
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_stored    <= '0;
            r_prev      <= '0;
            r_pct       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_last      <= n_last;
                r_stored    <= n_stored;
                r_prev      <= n_prev;
                r_pct       <= n_pct;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/asd_chk.sv]
module asd_chk
    import asd_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.percent <= PCT_W'(PCT_FULL)))
        else $error("percent above full scale");

    a_changed_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.changed == (o_out_data.reason == REASON_MOVED)))
        else $error("changed flag disagrees with reason");

    a_reason_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.reason == REASON_NONE ||
                         o_out_data.reason == REASON_MOVED ||
                         o_out_data.reason == REASON_INIT))
        else $error("undefined reason code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind analog_slider_deadband asd_chk u_asd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[test/analog_slider_deadband_test.sv]
`timescale 1ns / 1ps

module analog_slider_deadband_test;
    import asd_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int RAND_PHASES = 9;
    localparam int PHASE_ITEMS = 215;

    class slider_scoreboard;
        int                zofs;
        logic [RAW_W-1:0]  thresh;
        logic [TIME_W-1:0] interval;
        logic              inv;
        logic [TIME_W-1:0] last_read;
        int                raw_cur;
        int                raw_prev;
        int unsigned       pct;
        t_out              expected_q[$];
        int                err_count;

        function new();
            zofs      = int'($signed(ZERO_OFFSET_RST));
            thresh    = RAW_THRESHOLD_RST;
            interval  = INTERVAL_MS_RST;
            inv       = INVERT_RST;
            last_read = '0;
            raw_cur   = 0;
            raw_prev  = 0;
            pct       = 0;
            err_count = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_ZERO_OFFSET: begin
                    zofs = int'($signed(d[OFFSET_W-1:0]));
                end
                CFG_RAW_THRESHOLD: begin
                    thresh = d[RAW_W-1:0];
                end
                CFG_INTERVAL_MS: begin
                    interval = d[TIME_W-1:0];
                end
                default: begin
                    inv = d[0];
                end
            endcase
        endfunction

        function int clamp_adc(int v);
            if (v < 0)
                return 0;
            if (v > int'(ADC_MAX_DEF))
                return int'(ADC_MAX_DEF);
            return v;
        endfunction

        function int unsigned percent_of(int v);
            int unsigned p;
            p = (unsigned'(clamp_adc(v)) * PCT_FULL) / ADC_MAX_DEF;
            return (p > PCT_FULL) ? PCT_FULL : p;
        endfunction

        // one accepted input transaction -> one expected result
        function void note_input(t_in x);
            t_out              exp;
            logic [TIME_W-1:0] dt;
            int                nr;
            int                diff;
            int unsigned       np;
            exp.changed = 1'b0;
            exp.reason  = REASON_NONE;
            if (x.mode == MODE_INIT) begin
                // init keeps the unclamped value
                raw_cur    = int'(x.sample) - zofs;
                pct        = percent_of(raw_cur);
                exp.reason = REASON_INIT;
            end else begin
                dt = x.now_ms - last_read;
                if (dt >= interval) begin
                    last_read = x.now_ms;
                    nr = clamp_adc(int'(x.sample) - zofs);
                    if (inv)
                        nr = int'(ADC_MAX_DEF) - nr;
                    diff = nr - raw_cur;
                    if (diff < 0)
                        diff = -diff;
                    if (diff >= int'(thresh)) begin
                        raw_prev = raw_cur;
                        raw_cur  = nr;
                        np       = percent_of(nr);
                        if (np != pct) begin
                            pct         = np;
                            exp.changed = 1'b1;
                            exp.reason  = REASON_MOVED;
                        end
                    end
                end
            end
            exp.percent    = PCT_W'(pct);
            exp.raw_now    = RAW_W'(clamp_adc(raw_cur));
            exp.raw_before = RAW_W'(clamp_adc(raw_prev));
            expected_q.push_back(exp);
        endfunction

        function void compare_field(string name, logic [31:0] e, logic [31:0] a);
            if (a !== e) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
                err_count++;
            end
        endfunction

        function void check_result(t_out got);
            t_out exp;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected: actual %h", $time, got);
                err_count++;
                return;
            end
            exp = expected_q.pop_front();
            compare_field("changed", 32'(exp.changed), 32'(got.changed));
            compare_field("percent", 32'(exp.percent), 32'(got.percent));
            compare_field("raw_now", 32'(exp.raw_now), 32'(got.raw_now));
            compare_field("raw_before", 32'(exp.raw_before), 32'(got.raw_before));
            compare_field("reason", 32'(exp.reason), 32'(got.reason));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  o_in_ready;
    t_in                   in_data;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    t_out                  o_out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    slider_scoreboard  sb;
    bit                idle_on;
    int                stall_left = 0;
    int                quiet_cycles = 0;
    logic [TIME_W-1:0] tb_now;
    int                last_smp;

    analog_slider_deadband DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // result side: random back-pressure bursts and checking
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
        if (i_rst_n && o_out_valid && out_ready)
            sb.check_result(o_out_data);
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input t_in x);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_input(x);
    endtask

    task automatic send_fields(input logic mode, input logic [TIME_W-1:0] now,
                               input int smp);
        t_in x;
        x.mode   = mode;
        x.now_ms = now;
        x.sample = RAW_W'(smp);
        send_item(x);
    endtask

    // stop sending and wait until every expected result is back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.expected_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input int ofs, input int thr, input logic [TIME_W-1:0] intv,
                              input bit inv);
        logic [CFG_DATA_W-1:0] vals[4];
        t_cfg_idx              idx;
        vals[0] = CFG_DATA_W'(ofs);
        vals[1] = CFG_DATA_W'(thr);
        vals[2] = intv;
        vals[3] = CFG_DATA_W'(inv);
        cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            idx = t_cfg_idx'(i);
            cfg_index <= idx;
            cfg_data  <= vals[i];
            sb.write_reg(idx, vals[i]);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        int                ofs;
        int                thr;
        logic [TIME_W-1:0] intv;
        case ($urandom_range(0, 4))
            0: ofs = -4095;
            1: ofs = 4095;
            2: ofs = 0;
            3: ofs = $urandom_range(0, 400) - 200;
            default: ofs = $urandom_range(0, 8190) - 4095;
        endcase
        case ($urandom_range(0, 4))
            0: thr = 0;
            1: thr = 4095;
            2: thr = $urandom_range(0, 4095);
            default: thr = $urandom_range(1, 40);
        endcase
        case ($urandom_range(0, 5))
            0: intv = '0;
            1: intv = '1;
            2: intv = $urandom();
            3: intv = 50;
            default: intv = $urandom_range(0, 100);
        endcase
        set_config(ofs, thr, intv, 1'($urandom_range(0, 1)));
    endtask

    // timestamps mostly around the read interval, samples as a random walk
    task automatic random_item();
        logic mode;
        int   smp;
        mode = ($urandom_range(0, 15) == 0) ? MODE_INIT : MODE_UPDATE;
        case ($urandom_range(0, 9))
            0, 1: tb_now = tb_now + TIME_W'($urandom_range(0, 120));
            2: tb_now = sb.last_read + sb.interval;
            3: tb_now = sb.last_read + sb.interval - 1;
            4: tb_now = $urandom();
            default: tb_now = sb.last_read + sb.interval + TIME_W'($urandom_range(0, 20));
        endcase
        case ($urandom_range(0, 7))
            0: smp = $urandom_range(0, 4095);
            1: smp = 0;
            2: smp = 4095;
            default: begin
                smp = last_smp + $urandom_range(0, 128) - 64;
                if (smp < 0)
                    smp = 0;
                if (smp > 4095)
                    smp = 4095;
            end
        endcase
        last_smp = smp;
        send_fields(mode, tb_now, smp);
    endtask

    initial begin
        sb           = new();
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_ZERO_OFFSET;
        cfg_data     = '0;
        idle_on      = 1'b1;
        tb_now       = '0;
        last_smp     = 2048;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: interval, threshold, same-percent move, timestamp wrap
        send_fields(MODE_UPDATE, 32'd0, 4095);
        send_fields(MODE_UPDATE, 32'd50, 4095);
        send_fields(MODE_UPDATE, 32'd60, 0);
        send_fields(MODE_UPDATE, 32'd100, 4090);
        send_fields(MODE_UPDATE, 32'd200, 2000);
        send_fields(MODE_UPDATE, 32'd250, 1990);
        send_fields(MODE_UPDATE, 32'hFFFF_FFF0, 1000);
        send_fields(MODE_UPDATE, 32'h0000_0010, 3000);
        send_fields(MODE_UPDATE, 32'h0000_0022, 3000);
        send_fields(MODE_INIT, 32'h5555_5555, 2730);
        drain();

        // negative offset extreme: unclamped init, zero threshold and interval, mirror
        set_config(-4095, 0, '0, 1'b1);
        send_fields(MODE_INIT, 32'hAAAA_AAAA, 4095);
        send_fields(MODE_UPDATE, 32'hAAAA_AAAA, 0);
        send_fields(MODE_UPDATE, 32'h0, 0);
        send_fields(MODE_INIT, 32'h0, 0);
        send_fields(MODE_UPDATE, 32'hFFFF_FFFF, 4095);
        drain();

        // positive offset extreme, full threshold, longest interval
        set_config(4095, 4095, '1, 1'b0);
        send_fields(MODE_INIT, 32'h0, 0);
        send_fields(MODE_UPDATE, sb.last_read, 4095);
        send_fields(MODE_UPDATE, sb.last_read - 1, 4095);
        send_fields(MODE_UPDATE, sb.last_read - 1, 0);
        send_fields(MODE_INIT, 32'h1234_5678, 4095);
        send_fields(MODE_UPDATE, sb.last_read - 2, 2048);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0)
                set_config(0, 10, 32'd50, 1'b0);
            else
                random_config();
            if (ph == RAND_PHASES - 1)
                idle_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.err_count == 0 && sb.expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
